>>> design/smc_pkg.sv
package smc_pkg;

   localparam int CAPACITY   = 256;
   localparam int VALUE_BITS = 20;

   localparam int OPCODE_BITS = 2;
   localparam int ITEM_BITS   = 20;
   localparam int RANK_BITS   = 8;
   localparam int RESULT_BITS = 20;
   localparam int STATUS_BITS = 2;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > RANK_BITS) ? CNT_W : RANK_BITS;

   localparam int GROUP_SIZE = 16;
   localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

   localparam logic [OPCODE_BITS-1:0] OP_ADD    = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_REMOVE = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_READ   = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_RANK = 2'd2;

   typedef struct packed {
      logic [OPCODE_BITS-1:0] opcode;
      logic [ITEM_BITS-1:0]   item_value;
      logic [RANK_BITS-1:0]   rank;
   } req_type;

   typedef struct packed {
      logic [RESULT_BITS-1:0] result_value;
      logic [STATUS_BITS-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic                  add_en;
      logic                  remove_en;
      logic [VALUE_BITS-1:0] ins_value;
      logic [CMP_W-1:0]      rank;
      logic [CMP_W-1:0]      count;
   } cell_ctl_type;

   typedef enum logic {
      PH_IDLE,
      PH_PICK
   } phase_type;

endpackage

>>> design/smc_cell.sv
module smc_cell (
   input  logic                          clock,
   input  smc_pkg::cell_ctl_type         ctl,
   input  logic [smc_pkg::CMP_W-1:0]     cell_index,
   input  logic                          left_le,
   input  logic [smc_pkg::VALUE_BITS-1:0] left_value,
   input  logic [smc_pkg::VALUE_BITS-1:0] right_value,
   output logic                          le_out,
   output logic [smc_pkg::VALUE_BITS-1:0] value_out,
   output logic [smc_pkg::VALUE_BITS-1:0] sel_value
);
   import smc_pkg::*;

   logic [VALUE_BITS-1:0] val_ff;
   logic [VALUE_BITS-1:0] val_in;
   logic                  in_range;

   assign in_range  = cell_index < ctl.count;
   assign le_out    = in_range && (val_ff <= ctl.ins_value);
   assign value_out = val_ff;
   assign sel_value = (in_range && (cell_index == ctl.rank)) ? val_ff : '0;

   always_comb begin
      val_in = val_ff;
      if (ctl.add_en && !le_out) begin
         val_in = left_le ? ctl.ins_value : left_value;
      end else if (ctl.remove_en && (cell_index >= ctl.rank)) begin
         val_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

>>> design/smc_select.sv
module smc_select (
   input  logic                           clock,
   input  logic                           load,
   input  logic [smc_pkg::VALUE_BITS-1:0] sel_values [smc_pkg::CAPACITY],
   output logic [smc_pkg::VALUE_BITS-1:0] picked
);
   import smc_pkg::*;

   logic [VALUE_BITS-1:0] grp_ff [NUM_GROUPS];
   logic [VALUE_BITS-1:0] grp_in [NUM_GROUPS];

   // at most one cell drives a nonzero value, so an or tree picks it
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (g * GROUP_SIZE + k < CAPACITY) begin
               grp_in[g] = grp_in[g] | sel_values[g * GROUP_SIZE + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         grp_ff <= grp_in;
      end
   end

   always_comb begin
      picked = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         picked = picked | grp_ff[g];
      end
   end

endmodule

>>> design/sorted_multiset_order_statistic.sv
// Sorted multiset with rank access, held in a row of compare-and-shift cells.
// Command channel: a transfer happens at a rising edge with start high and
// busy low. req_data.opcode selects add (insert req_data.item_value after equal
// values), remove (delete and return the value at req_data.rank) or read
// (return the value at req_data.rank, nothing changes).
// Result channel: rsp_valid is high for exactly one cycle with
// rsp_data.result_value and rsp_data.status; the receiver cannot stall it, so it
// must take it then.
// Datapath: the cells update at the command transfer edge, where the rank pick
// is also registered in the group stage of a registered two-level or tree over
// the cells; the second level feeds the result register, which drives the
// result ports. busy is high in the cycle after a transfer, while the tree
// output is taken, so no new command is taken before the last one is through.
// Errors: add to a full store gives status 1, a rank not below the count gives
// status 2; both leave the store as it was and return value zero.
// Reset: synchronous, active high; the count goes to zero and the block is
// ready in the next cycle. Cell contents need no clearing.
module sorted_multiset_order_statistic (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  smc_pkg::req_type  req_data,
   output logic              rsp_valid,
   output smc_pkg::rsp_type  rsp_data
);
   import smc_pkg::*;

   phase_type             phase_ff;
   phase_type             phase_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic [OPCODE_BITS-1:0] op_ff;
   logic [STATUS_BITS-1:0] status_ff;
   logic [STATUS_BITS-1:0] status_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;

   logic                  accept;
   logic                  full;
   logic                  rank_bad;
   logic [CMP_W-1:0]      rank_ext;
   logic [CMP_W-1:0]      count_ext;
   cell_ctl_type          ctl;
   logic [VALUE_BITS-1:0] picked;

   logic [VALUE_BITS-1:0] cell_value [CAPACITY];
   logic [VALUE_BITS-1:0] sel_values [CAPACITY];
   logic                  cell_le    [CAPACITY];

   assign busy      = (phase_ff == PH_PICK);
   assign accept    = start && !busy;
   assign rank_ext  = CMP_W'(req_data.rank);
   assign count_ext = CMP_W'(count_ff);
   assign full      = (count_ext == CMP_W'(CAPACITY));
   assign rank_bad  = (rank_ext >= count_ext);

   always_comb begin
      ctl.add_en    = accept && (req_data.opcode == OP_ADD) && !full;
      ctl.remove_en = accept && (req_data.opcode == OP_REMOVE) && !rank_bad;
      ctl.ins_value = VALUE_BITS'(req_data.item_value);
      ctl.rank      = rank_ext;
      ctl.count     = count_ext;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                  left_le;
      logic [VALUE_BITS-1:0] left_value;
      logic [VALUE_BITS-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_le    = 1'b1;
         assign left_value = ctl.ins_value;
      end else begin : g_mid
         assign left_le    = cell_le[i-1];
         assign left_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_inner
         assign right_value = cell_value[i+1];
      end

      smc_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .cell_index (CMP_W'(i)),
         .left_le    (left_le),
         .left_value (left_value),
         .right_value(right_value),
         .le_out     (cell_le[i]),
         .value_out  (cell_value[i]),
         .sel_value  (sel_values[i])
      );
   end

   smc_select u_select (
      .clock     (clock),
      .load      (accept),
      .sel_values(sel_values),
      .picked    (picked)
   );

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      status_in    = ST_OK;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      case (req_data.opcode)
         OP_ADD:    status_in = full ? ST_FULL : ST_OK;
         OP_REMOVE: status_in = rank_bad ? ST_RANK : ST_OK;
         OP_READ:   status_in = rank_bad ? ST_RANK : ST_OK;
         default:   status_in = ST_OK;
      endcase

      case (phase_ff)
         PH_IDLE: begin
            if (accept) begin
               phase_in = PH_PICK;
               if (ctl.add_en) begin
                  count_in = count_ff + CNT_W'(1);
               end else if (ctl.remove_en) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         PH_PICK: begin
            phase_in     = PH_IDLE;
            rsp_valid_in = 1'b1;
            rsp_in.status = status_ff;
            if ((status_ff == ST_OK) && ((op_ff == OP_REMOVE) || (op_ff == OP_READ))) begin
               rsp_in.result_value = RESULT_BITS'(picked);
            end else begin
               rsp_in.result_value = '0;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_data.opcode;
         status_ff <= status_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> tb/tb.sv
module tb;
   import smc_pkg::*;

   localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 2000;
   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 8;

   typedef struct {
      req_type cmd;
      bit      fixed_want;
      rsp_type want;
   } step_row_type;

   typedef enum {FILLING, DRAINING, CHURNING} traffic_mode_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req = '0;
   logic    rsp_valid;
   rsp_type rsp;

   logic [VALUE_BITS-1:0] held_values [CAPACITY];
   int held_count = 0;
   rsp_type expected_rsp_q [$];
   rsp_type oldest_rsp;
   step_row_type directed_steps [$];
   int mismatch_count = 0;
   int idle_cycles = 0;
   int burst_left = 4;

   sorted_multiset_order_statistic dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp)
   );

   always #4 clock = ~clock;

   // sorted insert after equal values, rank remove and rank read
   function automatic rsp_type multiset_apply(input req_type cmd);
      rsp_type outcome;
      logic [VALUE_BITS-1:0] v;
      int pos;
      outcome = '0;
      outcome.status = ST_OK;
      v = cmd.item_value[VALUE_BITS-1:0];
      case (cmd.opcode)
         OP_ADD: begin
            if (held_count >= CAPACITY) begin
               outcome.status = ST_FULL;
            end else begin
               pos = 0;
               while (pos < held_count && held_values[pos] <= v) pos++;
               for (int k = held_count; k > pos; k--) held_values[k] = held_values[k-1];
               held_values[pos] = v;
               held_count++;
            end
         end
         OP_REMOVE: begin
            if (int'(cmd.rank) >= held_count) begin
               outcome.status = ST_RANK;
            end else begin
               outcome.result_value = held_values[cmd.rank];
               for (int k = cmd.rank; k + 1 < held_count; k++) held_values[k] = held_values[k+1];
               held_count--;
            end
         end
         OP_READ: begin
            if (int'(cmd.rank) >= held_count) outcome.status = ST_RANK;
            else outcome.result_value = held_values[cmd.rank];
         end
         default: ;
      endcase
      return outcome;
   endfunction

   function automatic step_row_type row(input logic [OPCODE_BITS-1:0] op,
                                        input logic [ITEM_BITS-1:0] value,
                                        input logic [RANK_BITS-1:0] rank,
                                        input bit fixed,
                                        input logic [RESULT_BITS-1:0] want_value,
                                        input logic [STATUS_BITS-1:0] want_status);
      step_row_type r;
      r.cmd.opcode = op;
      r.cmd.item_value = value;
      r.cmd.rank = rank;
      r.fixed_want = fixed;
      r.want.result_value = want_value;
      r.want.status = want_status;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // one command transfer, then burst pacing
   task automatic issue(input req_type cmd, input bit fixed, input rsp_type want);
      bit accepted;
      rsp_type predicted;
      int gap;
      start <= 1'b1;
      req <= cmd;
      do begin
         @(negedge clock);
         accepted = (busy === 1'b0);
         @(posedge clock);
      end while (!accepted);
      predicted = multiset_apply(cmd);
      expected_rsp_q.push_back(fixed ? want : predicted);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 16);
         gap = $urandom_range(1, 12);
         start <= 1'b0;
         req <= req_type'($bits(req_type)'({$urandom, $urandom}));
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(negedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("result with nothing pending", 32'(rsp), 32'd0);
         end else begin
            oldest_rsp = expected_rsp_q.pop_front();
            if (rsp.result_value !== oldest_rsp.result_value)
               report_mismatch("result_value", 32'(rsp.result_value),
                               32'(oldest_rsp.result_value));
            if (rsp.status !== oldest_rsp.status)
               report_mismatch("status", 32'(rsp.status), 32'(oldest_rsp.status));
         end
      end
   end

   always @(negedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer in %0d cycles", IDLE_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      req_type cmd;
      traffic_mode_type mode;
      int full_hits;
      int roll;
      int add_pct;

      directed_steps.push_back(row(OP_READ,   20'h00000, 8'd0,   1'b1, 20'h0, ST_RANK));
      directed_steps.push_back(row(OP_REMOVE, 20'h00000, 8'd0,   1'b1, 20'h0, ST_RANK));
      directed_steps.push_back(row(OP_REMOVE, 20'h00000, 8'd255, 1'b1, 20'h0, ST_RANK));
      directed_steps.push_back(row(OP_UNUSED, 20'hFFFFF, 8'd255, 1'b1, 20'h0, ST_OK));
      directed_steps.push_back(row(OP_ADD,    20'hFFFFF, 8'd255, 1'b1, 20'h0, ST_OK));
      directed_steps.push_back(row(OP_ADD,    20'h00000, 8'd0,   1'b1, 20'h0, ST_OK));
      directed_steps.push_back(row(OP_ADD,    20'h80000, 8'd0,   1'b1, 20'h0, ST_OK));
      directed_steps.push_back(row(OP_ADD,    20'h80000, 8'd0,   1'b1, 20'h0, ST_OK));
      directed_steps.push_back(row(OP_ADD,    20'h7FFFF, 8'd0,   1'b1, 20'h0, ST_OK));
      directed_steps.push_back(row(OP_READ,   20'hFFFFF, 8'd0,   1'b1, 20'h0, ST_OK));
      directed_steps.push_back(row(OP_READ,   20'h00000, 8'd4,   1'b1, 20'hFFFFF, ST_OK));
      directed_steps.push_back(row(OP_READ,   20'h00000, 8'd5,   1'b1, 20'h0, ST_RANK));
      directed_steps.push_back(row(OP_READ,   20'h00000, 8'd255, 1'b1, 20'h0, ST_RANK));
      directed_steps.push_back(row(OP_REMOVE, 20'h00000, 8'd2,   1'b0, 20'h0, ST_OK));
      directed_steps.push_back(row(OP_READ,   20'h00000, 8'd2,   1'b0, 20'h0, ST_OK));
      directed_steps.push_back(row(OP_REMOVE, 20'h00000, 8'd3,   1'b0, 20'h0, ST_OK));
      directed_steps.push_back(row(OP_REMOVE, 20'h00000, 8'd0,   1'b0, 20'h0, ST_OK));
      directed_steps.push_back(row(OP_ADD,    20'h55555, 8'd0,   1'b0, 20'h0, ST_OK));
      directed_steps.push_back(row(OP_ADD,    20'hAAAAA, 8'd0,   1'b0, 20'h0, ST_OK));
      directed_steps.push_back(row(OP_READ,   20'h00000, 8'd1,   1'b0, 20'h0, ST_OK));
      directed_steps.push_back(row(OP_UNUSED, 20'h00000, 8'd0,   1'b1, 20'h0, ST_OK));
      directed_steps.push_back(row(OP_REMOVE, 20'hFFFFF, 8'd255, 1'b1, 20'h0, ST_RANK));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_steps[i])
         issue(directed_steps[i].cmd, directed_steps[i].fixed_want, directed_steps[i].want);

      // random part: fill to capacity, drain to empty, churn in between
      mode = FILLING;
      full_hits = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         case (mode)
            FILLING:  add_pct = 80;
            DRAINING: add_pct = 15;
            default:  add_pct = 45;
         endcase
         cmd = req_type'($bits(req_type)'({$urandom, $urandom}));
         roll = $urandom_range(0, 99);
         if (roll < 3) cmd.opcode = OP_UNUSED;
         else if (roll < 3 + add_pct) cmd.opcode = OP_ADD;
         else cmd.opcode = ($urandom_range(0, 1) == 0) ? OP_REMOVE : OP_READ;
         case ($urandom_range(0, 9))
            0: cmd.item_value = '0;
            1: cmd.item_value = '1;
            2, 3, 4: cmd.item_value = ITEM_BITS'($urandom_range(0, 15));
            default: cmd.item_value = ITEM_BITS'($urandom);
         endcase
         if (held_count > 0 && $urandom_range(0, 9) != 0)
            cmd.rank = RANK_BITS'($urandom_range(0, (held_count > 256 ? 256 : held_count) - 1));
         else
            cmd.rank = RANK_BITS'($urandom_range(0, 255));
         issue(cmd, 1'b0, '0);
         if (held_count >= CAPACITY) begin
            full_hits++;
            if (full_hits > 4) begin
               mode = DRAINING;
               full_hits = 0;
            end
         end
         if (held_count == 0 && mode == DRAINING)
            mode = ($urandom_range(0, 2) == 0) ? CHURNING : FILLING;
         if (mode == CHURNING && $urandom_range(0, 199) == 0) mode = FILLING;
      end

      start <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> sorted_multiset_order_statistic.f
design/smc_pkg.sv
design/smc_cell.sv
design/smc_select.sv
design/sorted_multiset_order_statistic.sv
tb/tb.sv
